FILE: rtl/grid_min_path_sum_core_macros.svh
// ----------------------------------------------------------------------------
// grid_min_path_sum_core_macros
// Assertion macros for the grid minimum path sum core.
// ----------------------------------------------------------------------------
`ifndef GRID_MIN_PATH_SUM_CORE_MACROS_SVH
`define GRID_MIN_PATH_SUM_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GMPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmps assertion failed");
`define GMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmps assertion failed");
`else
`define GMPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/gmps_pkg.sv
// ----------------------------------------------------------------------------
// gmps_pkg
// Shared constants and types of the grid minimum path sum core.
// ----------------------------------------------------------------------------
package gmps_pkg;

    localparam int MAX_COLS_DEFAULT = 256;
    localparam int COST_W           = 16;
    localparam int SUM_W            = 32;
    localparam int RW_W             = 9;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 2;

    localparam logic [RW_W-1:0]       ROW_WIDTH_RESET = 9'd256;
    localparam logic [APB_ADDR_W-1:0] ADDR_ROW_WIDTH  = 2'd0;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              last;
        logic              first_row;
    } cell_ctl_t;

endpackage

FILE: rtl/gmps_front.sv
// ----------------------------------------------------------------------------
// gmps_front
// Accepts cells, tracks column and top row, and tags each cell for the back.
// ----------------------------------------------------------------------------
module gmps_front #(
    parameter int MAX_COLS = gmps_pkg::MAX_COLS_DEFAULT,
    parameter int COL_W    = $clog2(MAX_COLS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [gmps_pkg::RW_W-1:0]   row_width,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [gmps_pkg::COST_W-1:0] s_tdata,    // cell_cost
    input  logic                        s_tlast,
    input  logic                        q_full,
    output logic                        push,
    output gmps_pkg::cell_ctl_t         entry,
    output logic [COL_W-1:0]            entry_col
);

    localparam int WW = (COL_W + 1 > gmps_pkg::RW_W) ? COL_W + 1 : gmps_pkg::RW_W;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             first_row_reg;
    logic             first_row_next;
    logic [WW-1:0]    rw_ext;
    logic [WW-1:0]    w_eff;
    logic             past_end;
    logic [COL_W-1:0] col_cur;
    logic             fr_cur;
    logic [COL_W:0]   col_inc;
    logic             wrap;

    always_comb
    begin
        rw_ext = WW'(row_width);
        if (rw_ext == '0)
        begin
            w_eff = WW'(1);
        end
        else if (rw_ext > WW'(MAX_COLS))
        begin
            w_eff = WW'(MAX_COLS);
        end
        else
        begin
            w_eff = rw_ext;
        end
        past_end = (WW'(col_reg) >= w_eff);
        col_cur  = past_end ? '0 : col_reg;
        fr_cur   = past_end ? 1'b0 : first_row_reg;
        col_inc  = {1'b0, col_cur} + (COL_W + 1)'(1);
        wrap     = (WW'(col_inc) >= w_eff);
    end

    assign s_tready        = !q_full;
    assign push            = s_tvalid && !q_full;
    assign entry.cost      = s_tdata;
    assign entry.last      = s_tlast;
    assign entry.first_row = fr_cur;
    assign entry_col       = col_cur;

    always_comb
    begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (push)
        begin
            if (s_tlast)
            begin
                col_next       = '0;
                first_row_next = 1'b1;
            end
            else if (wrap)
            begin
                col_next       = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next       = col_inc[COL_W-1:0];
                first_row_next = fr_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end
        else
        begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
        end
    end

endmodule

FILE: rtl/gmps_queue.sv
// ----------------------------------------------------------------------------
// gmps_queue
// Two-entry queue of tagged cells between the front and the back.
// ----------------------------------------------------------------------------
module gmps_queue #(
    parameter int COL_W = $clog2(gmps_pkg::MAX_COLS_DEFAULT)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gmps_pkg::cell_ctl_t push_entry,
    input  logic [COL_W-1:0]    push_col,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output gmps_pkg::cell_ctl_t head,
    output logic [COL_W-1:0]    head_col
);

    gmps_pkg::cell_ctl_t entry_reg [2];
    logic [COL_W-1:0]    col_reg [2];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign head_col   = col_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
            col_reg[wr_ptr_reg]   <= push_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/gmps_back.sv
// ----------------------------------------------------------------------------
// gmps_back
// Reads the row store, adds and saturates each cell's best cost, emits results.
// ----------------------------------------------------------------------------
`include "grid_min_path_sum_core_macros.svh"

module gmps_back #(
    parameter int MAX_COLS = gmps_pkg::MAX_COLS_DEFAULT,
    parameter int COL_W    = $clog2(MAX_COLS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  gmps_pkg::cell_ctl_t        head,
    input  logic [COL_W-1:0]           head_col,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [gmps_pkg::SUM_W-1:0] m_tdata,   // path_sum
    output logic                       m_tuser    // saturated
);

    localparam int SW = gmps_pkg::SUM_W;

    logic [SW-1:0]       row_store [MAX_COLS];
    logic [SW-1:0]       rdata_reg;
    logic                bypass_reg;
    logic                bypass_next;
    logic                b_valid_reg;
    logic                b_valid_next;
    gmps_pkg::cell_ctl_t b_reg;
    logic [COL_W-1:0]    b_col_reg;
    logic [SW-1:0]       left_best_reg;
    logic [SW-1:0]       left_best_next;
    logic                sat_seen_reg;
    logic                sat_seen_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SW-1:0]       path_sum_reg;
    logic                sat_out_reg;
    logic                b_fire;
    logic [SW-1:0]       up;
    logic [SW-1:0]       prior;
    logic [SW:0]         sum;
    logic                sat;
    logic [SW-1:0]       best;

    assign b_fire = b_valid_reg && !(b_reg.last && out_valid_reg && !m_tready);
    assign pop    = head_valid && (!b_valid_reg || b_fire);

    always_comb
    begin
        up = bypass_reg ? left_best_reg : rdata_reg;
        if (b_reg.first_row && (b_col_reg == '0))
        begin
            prior = '0;
        end
        else if (b_reg.first_row)
        begin
            prior = left_best_reg;
        end
        else if (b_col_reg == '0)
        begin
            prior = up;
        end
        else
        begin
            prior = (up < left_best_reg) ? up : left_best_reg;
        end
        sum  = {1'b0, prior} + (SW + 1)'(b_reg.cost);
        sat  = sum[SW];
        best = sat ? '1 : sum[SW-1:0];
    end

    always_comb
    begin
        bypass_next    = bypass_reg;
        b_valid_next   = b_valid_reg;
        left_best_next = left_best_reg;
        sat_seen_next  = sat_seen_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (b_fire)
        begin
            b_valid_next = 1'b0;
            if (b_reg.last)
            begin
                left_best_next = '0;
                sat_seen_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                left_best_next = best;
                sat_seen_next  = sat_seen_reg || sat;
            end
        end
        if (pop)
        begin
            b_valid_next = 1'b1;
            bypass_next  = b_fire && (head_col == b_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            row_store[b_col_reg] <= best;
        end
        if (pop)
        begin
            rdata_reg <= row_store[head_col];
            b_reg     <= head;
            b_col_reg <= head_col;
        end
        if (b_fire && b_reg.last)
        begin
            path_sum_reg <= best;
            sat_out_reg  <= sat_seen_reg || sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg    <= 1'b0;
            b_valid_reg   <= 1'b0;
            left_best_reg <= '0;
            sat_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bypass_reg    <= bypass_next;
            b_valid_reg   <= b_valid_next;
            left_best_reg <= left_best_next;
            sat_seen_reg  <= sat_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = path_sum_reg;
    assign m_tuser  = sat_out_reg;

    `GMPS_ASSERT_IMPLY(a_pop_needs_fire, clk, rst_n, pop && b_valid_reg, b_fire)
    `GMPS_ASSERT_NEXT(a_last_makes_result, clk, rst_n, b_fire && b_reg.last, out_valid_reg)
    `GMPS_ASSERT_NEXT(a_out_held, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `GMPS_ASSERT_NEXT(a_pop_loads_cell, clk, rst_n, pop, b_valid_reg)

endmodule

FILE: rtl/grid_min_path_sum_core.sv
// ----------------------------------------------------------------------------
// grid_min_path_sum_core
// Minimum right/down path sum over a grid of cell costs streamed row by row.
// ----------------------------------------------------------------------------
// Cells enter one per cycle in row-major order unless the queue is full; row
// width comes from the row_width register (0 acts as 1, above MAX_COLS acts
// as MAX_COLS), which the user must write only while the core is idle; the
// core does not enforce this. The front tags each cell with its column and
// top-row flag, a two-entry queue decouples it from the back, whose single
// add-compare-saturate step and row store, read and written in the same cycle,
// take one cell per cycle, stalled only when the next s_tlast cell reaches the
// back while m_tready low holds a result; such a cell passes the queue and
// the back's cell register to the output register. m_tuser flags that a
// partial sum of the grid saturated at 2^32-1. No clearing pass after reset.
// ----------------------------------------------------------------------------
module grid_min_path_sum_core #(
    parameter int MAX_COLS = gmps_pkg::MAX_COLS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gmps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gmps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gmps_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gmps_pkg::COST_W-1:0]     s_tdata,   // cell_cost
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gmps_pkg::SUM_W-1:0]      m_tdata,   // path_sum
    output logic                            m_tuser    // saturated
);

    localparam int COL_W = $clog2(MAX_COLS);

    logic [gmps_pkg::RW_W-1:0] row_width_reg;
    logic [gmps_pkg::RW_W-1:0] row_width_next;
    logic                      q_full;
    logic                      push;
    gmps_pkg::cell_ctl_t       entry;
    logic [COL_W-1:0]          entry_col;
    logic                      pop;
    logic                      head_valid;
    gmps_pkg::cell_ctl_t       head;
    logic [COL_W-1:0]          head_col;

    assign pready = 1'b1;

    always_comb
    begin
        row_width_next = row_width_reg;
        if (psel && penable && pwrite && pready)
        begin
            row_width_next = pwdata[gmps_pkg::RW_W-1:0];
        end
        unique case (paddr)
            gmps_pkg::ADDR_ROW_WIDTH:
                prdata = gmps_pkg::APB_DATA_W'(row_width_reg);
            default:
                prdata = gmps_pkg::APB_DATA_W'(row_width_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= gmps_pkg::ROW_WIDTH_RESET;
        end
        else
        begin
            row_width_reg <= row_width_next;
        end
    end

    gmps_front #(
        .MAX_COLS (MAX_COLS),
        .COL_W    (COL_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_width (row_width_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .entry     (entry),
        .entry_col (entry_col)
    );

    gmps_queue #(
        .COL_W (COL_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .push_col   (entry_col),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .head_col   (head_col)
    );

    gmps_back #(
        .MAX_COLS (MAX_COLS),
        .COL_W    (COL_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_col   (head_col),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: dv/gmps_path_checker.sv
// ----------------------------------------------------------------------------
// gmps_path_checker
// Predicts and checks the minimum path sums of the grid path sum core.
// ----------------------------------------------------------------------------
// Watches the register port and both stream channels. Tracks the row width
// register, keeps its own copy of the previous row's best costs, and rebuilds
// each cell's best cost as it is accepted. A flagged last cell queues the
// expected path sum and saturation flag. Every result beat is compared field
// by field against the oldest queued entry. Register reads are compared
// against the tracked row width.
// ----------------------------------------------------------------------------
module gmps_path_checker #(
    parameter int MAX_COLS = gmps_pkg::MAX_COLS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gmps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gmps_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [gmps_pkg::APB_DATA_W-1:0] prdata,
    input  logic                            pready,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [gmps_pkg::COST_W-1:0]     s_tdata,   // cell_cost
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [gmps_pkg::SUM_W-1:0]      m_tdata,   // path_sum
    input  logic                            m_tuser,   // saturated
    output int                              mismatch_count,
    output int                              results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import gmps_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0] path_sum;
        logic             saturated;
    } path_result_t;

    logic [RW_W-1:0]  row_width_reg = ROW_WIDTH_RESET;
    logic [SUM_W-1:0] row_best [MAX_COLS];
    int unsigned      next_col = 0;
    bit               top_row = 1'b1;
    logic [SUM_W-1:0] left_sum = '0;
    bit               sat_sticky = 1'b0;
    path_result_t     expected_paths [$];
    int               errors_seen = 0;
    int               pending_count = 0;

    assign mismatch_count  = errors_seen;
    assign results_pending = pending_count;

    function automatic int unsigned active_width();
        if (row_width_reg == '0)
            return 1;
        if (row_width_reg > MAX_COLS)
            return MAX_COLS;
        return row_width_reg;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("ERROR %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors_seen++;
    endtask

    task automatic restart_grid();
        next_col   = 0;
        top_row    = 1'b1;
        left_sum   = '0;
        sat_sticky = 1'b0;
    endtask

    task automatic accumulate_cell(input logic [COST_W-1:0] cost, input logic last);
        int unsigned      w;
        int unsigned      col;
        logic [SUM_W-1:0] prior;
        logic [SUM_W-1:0] up;
        logic [SUM_W:0]   total;
        logic [SUM_W-1:0] best;
        path_result_t     res;
        w   = active_width();
        col = next_col;
        if (col >= w)
        begin
            col     = 0;
            top_row = 1'b0;
        end
        up = row_best[col];
        if (top_row && col == 0)
            prior = '0;
        else if (top_row)
            prior = left_sum;
        else if (col == 0)
            prior = up;
        else
            prior = (up < left_sum) ? up : left_sum;
        total = {1'b0, prior} + {{(SUM_W+1-COST_W){1'b0}}, cost};
        if (total[SUM_W])
        begin
            best       = '1;
            sat_sticky = 1'b1;
        end
        else
        begin
            best = total[SUM_W-1:0];
        end
        row_best[col] = best;
        left_sum      = best;
        col++;
        if (col >= w)
        begin
            col     = 0;
            top_row = 1'b0;
        end
        next_col = col;
        if (last)
        begin
            res.path_sum  = best;
            res.saturated = sat_sticky;
            expected_paths.push_back(res);
            restart_grid();
        end
    endtask

    task automatic check_path(input logic [SUM_W-1:0] sum, input logic sat);
        path_result_t want;
        if (expected_paths.size() == 0)
        begin
            report_mismatch("result beat with no grid pending", sum, 0);
            return;
        end
        want = expected_paths.pop_front();
        if (sum !== want.path_sum)
            report_mismatch("path_sum", sum, want.path_sum);
        if (sat !== want.saturated)
            report_mismatch("saturated", sat, want.saturated);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg = ROW_WIDTH_RESET;
            for (int i = 0; i < MAX_COLS; i++)
                row_best[i] = '0;
            restart_grid();
            expected_paths.delete();
            pending_count <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == ADDR_ROW_WIDTH)
            begin
                if (pwrite)
                    row_width_reg = pwdata[RW_W-1:0];
                else if (prdata !== {{(APB_DATA_W-RW_W){1'b0}}, row_width_reg})
                    report_mismatch("row_width readback", prdata, row_width_reg);
            end
            if (s_tvalid && s_tready)
                accumulate_cell(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_path(m_tdata, m_tuser);
            pending_count <= expected_paths.size();
        end
    end

endmodule

FILE: dv/grid_min_path_sum_core_tb.sv
// ----------------------------------------------------------------------------
// grid_min_path_sum_core_tb
// Stimulus and verdict for the grid minimum path sum core.
// ----------------------------------------------------------------------------
// Drives cell costs and row width settings into the core; the path checker
// beside it predicts and compares every result. A short directed part covers
// cost extremes, early grid end, out-of-range widths and a width change in
// the middle of a grid. Random phases then sweep widths with random gaps on
// both channels, one long output hold-off to back the core up, and a
// gap-free closing phase.
// ----------------------------------------------------------------------------
module grid_min_path_sum_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gmps_pkg::*;

    localparam int MAX_COLS        = MAX_COLS_DEFAULT;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_COUNT     = 10;
    localparam int PHASE_CELLS     = 25;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [COST_W-1:0]     s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SUM_W-1:0]      m_tdata;
    logic                  m_tuser;

    int          mismatch_count;
    int          results_pending;
    bit          src_gaps      = 1'b1;
    bit          sink_stalls   = 1'b1;
    bit          hold_off_req  = 1'b0;
    int unsigned cur_width     = MAX_COLS;
    int unsigned cur_col       = 0;
    bit          cur_top       = 1'b1;
    int unsigned idle_cycles   = 0;

    grid_min_path_sum_core #(.MAX_COLS(MAX_COLS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gmps_path_checker #(.MAX_COLS(MAX_COLS)) path_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned width_in_use(input logic [RW_W-1:0] value);
        if (value == '0)
            return 1;
        if (value > MAX_COLS)
            return MAX_COLS;
        return value;
    endfunction

    function automatic logic [RW_W-1:0] width_code(input int unsigned w);
        if (w == 1 && $urandom_range(0, 1) == 0)
            return '0;
        if (w == MAX_COLS && $urandom_range(0, 1) == 0)
            return RW_W'($urandom_range(MAX_COLS + 1, (1 << RW_W) - 1));
        return RW_W'(w);
    endfunction

    function automatic logic [COST_W-1:0] random_cost();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return COST_W'($urandom_range(0, 15));
            default: return COST_W'($urandom());
        endcase
    endfunction

    task automatic apb_access(input bit is_write, input logic [RW_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_ROW_WIDTH;
        pwdata  <= {{(APB_DATA_W-RW_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // hold the input low until every grid result is out and the pipe is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(input logic [RW_W-1:0] value);
        wait_drained();
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
        cur_width = width_in_use(value);
    endtask

    task automatic send_cell(input logic [COST_W-1:0] cost, input logic last);
        if (src_gaps && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cost;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cur_col >= cur_width)
        begin
            cur_col = 0;
            cur_top = 1'b0;
        end
        cur_col++;
        if (cur_col >= cur_width)
        begin
            cur_col = 0;
            cur_top = 1'b0;
        end
        if (last)
        begin
            cur_col = 0;
            cur_top = 1'b1;
        end
    endtask

    task automatic send_run(input int unsigned cells, input bit ends_grid);
        for (int unsigned i = 0; i < cells; i++)
            send_cell(random_cost(), ends_grid && i == cells - 1);
    endtask

    // grow only on the top row so no unwritten row store entry is read
    task automatic change_width_mid_grid();
        int unsigned w;
        if (cur_top)
            w = $urandom_range(1, 16);
        else
            w = $urandom_range(1, cur_width);
        set_width(width_code(w));
    endtask

    task automatic run_phase(input int unsigned budget);
        int unsigned sent;
        int unsigned cells;
        int unsigned split;
        sent = 0;
        while (sent < budget)
        begin
            cells = $urandom_range(1, (cur_width * 4 < 60) ? cur_width * 4 : 60);
            if (cells > 1 && $urandom_range(0, 3) == 0)
            begin
                split = $urandom_range(1, cells - 1);
                send_run(split, 1'b0);
                change_width_mid_grid();
                send_run(cells - split, 1'b1);
            end
            else
            begin
                send_run(cells, 1'b1);
            end
            sent += cells;
        end
    endtask

    // sink side: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                m_tready <= 1'b0;
            end
            else if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
                break;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the width register
        wait_drained();
        apb_access(1'b0, '0);

        // single-cell grids at the cost extremes
        send_cell('0, 1'b1);
        send_cell('1, 1'b1);

        // 3x3 grid, then an early end on column 0 of the second row
        set_width(RW_W'(3));
        send_cell(COST_W'(1), 1'b0);
        send_cell(COST_W'(3), 1'b0);
        send_cell(COST_W'(1), 1'b0);
        send_cell(COST_W'(1), 1'b0);
        send_cell(COST_W'(5), 1'b0);
        send_cell(COST_W'(1), 1'b0);
        send_cell(COST_W'(4), 1'b0);
        send_cell(COST_W'(2), 1'b0);
        send_cell(COST_W'(1), 1'b1);
        send_run(4, 1'b1);

        // width zero and above the column limit
        set_width('0);
        send_run(3, 1'b1);
        set_width('1);
        send_cell('1, 1'b0);
        send_cell('1, 1'b1);

        // shrink below the current column in the middle of a grid
        set_width(RW_W'(4));
        send_run(6, 1'b0);
        set_width(RW_W'(2));
        send_run(2, 1'b1);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            src_gaps    = (p != PHASE_COUNT - 1);
            sink_stalls = (p != PHASE_COUNT - 1);
            case (p)
                0:       set_width(RW_W'(1));
                1:       set_width(RW_W'(2));
                2:       set_width('0);
                3:       set_width(RW_W'(MAX_COLS));
                4:       set_width(RW_W'($urandom_range(MAX_COLS + 1, (1 << RW_W) - 1)));
                default: set_width(RW_W'($urandom_range(3, 16)));
            endcase
            if (p == 3)
                send_run(MAX_COLS + $urandom_range(1, 24), 1'b1);
            else
                run_phase(PHASE_CELLS);
            if (p == 4)
            begin
                // back the core up behind a stalled output
                hold_off_req = 1'b1;
                src_gaps     = 1'b0;
                for (int i = 0; i < 24; i++)
                    send_cell(random_cost(), 1'b1);
                src_gaps = 1'b1;
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/gmps_pkg.sv
rtl/gmps_front.sv
rtl/gmps_queue.sv
rtl/gmps_back.sv
rtl/grid_min_path_sum_core.sv
dv/gmps_path_checker.sv
dv/grid_min_path_sum_core_tb.sv
